// File: rtl/core/fumd_pkg.sv
package fumd_pkg;

  typedef enum logic [1:0] {
    KIND_TRACK   = 2'd0,
    KIND_METER   = 2'd1,
    KIND_GONE    = 2'd2,
    KIND_CONFIRM = 2'd3
  } kind_e;

  localparam logic [1:0] REG_FEE_SEC  = 2'd0;
  localparam logic [1:0] REG_FEE_MEM  = 2'd1;
  localparam logic [1:0] REG_FEE_SENT = 2'd2;
  localparam logic [1:0] REG_FEE_RECV = 2'd3;

  localparam int DivBits = 96;

  // 1000000 = 2^6 * 15625 and 86400 = 2^7 * 675; the odd factors are taken
  // by multiplying with ceil(2^k / factor), exact for digits below 2^30
  localparam int          SecPow    = 6;
  localparam int          DayPow    = 7;
  localparam int          SecShift  = 44;
  localparam int          DayShift  = 40;
  localparam logic [13:0] SEC_ODD   = 14'd15625;
  localparam logic [13:0] DAY_ODD   = 14'd675;
  localparam logic [30:0] SEC_RECIP = 31'd1125899907;
  localparam logic [30:0] DAY_RECIP = 31'd1628906116;

  localparam int AgeW = 45;
  localparam int SumW = 98;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  channel_index;
    logic [63:0] now_us;
    logic [63:0] bytes_sent;
    logic [63:0] bytes_received;
    logic [63:0] mem_byte_seconds;
    logic        payer_present;
    logic [63:0] confirmed_amount;
  } item_t;

  typedef struct packed {
    logic            status;
    logic [63:0]     debit;
    logic            charge_request;
    logic [63:0]     delta_sent;
    logic [63:0]     delta_received;
    logic [63:0]     delta_mem;
    logic [AgeW-1:0] age_seconds;
    logic [63:0]     total_debit;
  } result_t;

  typedef struct packed {
    logic        payer;
    logic [63:0] base_sent;
    logic [63:0] base_recv;
    logic [63:0] base_mem;
    logic [63:0] last_time;
    logic [63:0] total;
  } entry_t;

  function automatic logic [63:0] guarded(logic [63:0] cur, logic [63:0] last);
    return (cur >= last) ? cur - last : cur;
  endfunction

endpackage

// File: rtl/core/fumd_stream_if.sv
interface fumd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/flow_usage_metering_debit.sv
// Per-channel usage metering table, one item in work at a time. The transfer
// starts the synchronous table read, the next cycle reads, modifies and writes
// back the entry, and then the done state moves the result into the output
// register once that is free. This is the whole path for track, gone and confirm
// items and for any item on an untracked slot. A meter item on a tracked slot
// then has its whole seconds divided out in the shared constant divider
// (reciprocal multiplication, one 16-bit digit at a time); one 32x32 multiplier
// builds the four rate products from eight registered partial products, and the
// memory byte-day term goes through the same divider between the memory and the
// seconds products; then the sum is saturated and loaded into the output. A new
// item is taken while the last result still waits on the output; a finished
// result waits for the output register to free.
// Entry state lives in one RAM; the valid bits are flops cleared by reset.
module flow_usage_metering_debit import fumd_pkg::*; #(
  parameter int CHANNELS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  fumd_stream_if.sink   item_i,
  fumd_stream_if.source res_o
);
  localparam int Slots = (CHANNELS < 256) ? CHANNELS : 256;
  localparam int AW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int EW    = $bits(entry_t);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOK   = 3'd1;
  localparam logic [2:0] ST_AGE    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_MSTART = 3'd4;
  localparam logic [2:0] ST_MDIV   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]      state_q;
  logic [31:0]     fee_q [4];
  logic [Slots-1:0] valid_q;
  item_t           item_q;
  result_t         res_q, out_q;
  result_t         res_d;
  logic            out_valid_q;
  logic            payer_q;
  logic [63:0]     ds_q, dr_q, dm_q;
  logic [AgeW-1:0] age_q;
  logic [3:0]      step_q;
  logic [63:0]     prod_q;
  logic [95:0]     memprod_q;
  logic [SumW-1:0] sum_q;

  logic [AW-1:0]   addr;
  logic            in_table, hit;
  entry_t          ent, ent_new;
  logic            ram_we;
  logic [EW-1:0]   ram_rdata;
  logic            div_start, div_done, div_day;
  logic [DivBits-1:0] div_dvd, div_quot;
  logic [63:0]     op_sel, age_diff;
  logic [31:0]     op_half, fee_sel;
  logic [95:0]     term;
  logic [63:0]     debit;

  assign addr     = item_q.channel_index[AW-1:0];
  assign in_table = (32'(item_q.channel_index) < Slots);
  assign hit      = in_table && valid_q[addr];
  assign ent      = entry_t'(ram_rdata);
  assign age_diff = item_q.now_us - ent.last_time;

  fumd_ram #(.WIDTH(EW), .DEPTH(Slots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (EW'(ent_new)),
    .raddr_i (item_i.data.channel_index[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  fumd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .day_i      (div_day),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // entry update, written back in the lookup cycle
  always_comb begin
    ent_new = ent;
    ram_we  = 1'b0;
    if (state_q == ST_LOOK) begin
      unique case (item_q.kind)
        KIND_TRACK: begin
          ram_we = in_table;
          if (!hit) begin
            ent_new.base_sent = '0;
            ent_new.base_recv = '0;
            ent_new.base_mem  = '0;
            ent_new.last_time = '0;
            ent_new.total     = '0;
          end
          ent_new.payer = item_q.payer_present;
          if (ent_new.last_time == '0) begin
            ent_new.last_time = item_q.now_us;
          end
        end
        KIND_METER: begin
          ram_we            = hit;
          ent_new.base_sent = item_q.bytes_sent;
          ent_new.base_recv = item_q.bytes_received;
          ent_new.base_mem  = item_q.mem_byte_seconds;
          ent_new.last_time = item_q.now_us;
        end
        KIND_CONFIRM: begin
          ram_we        = hit;
          ent_new.total = ent.total + item_q.confirmed_amount;
        end
        KIND_GONE: ram_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_day   = 1'b0;
    div_dvd   = {32'd0, age_diff};
    if (state_q == ST_LOOK) begin
      div_start = hit && (item_q.kind == KIND_METER);
    end else if (state_q == ST_MSTART) begin
      div_start = 1'b1;
      div_day   = 1'b1;
      div_dvd   = memprod_q;
    end
  end

  always_comb begin
    unique case (step_q[3:2])
      2'd0: begin op_sel = ds_q; fee_sel = fee_q[REG_FEE_SENT]; end
      2'd1: begin op_sel = dr_q; fee_sel = fee_q[REG_FEE_RECV]; end
      2'd2: begin op_sel = dm_q; fee_sel = fee_q[REG_FEE_MEM]; end
      default: begin op_sel = 64'(age_q); fee_sel = fee_q[REG_FEE_SEC]; end
    endcase
    op_half = step_q[1] ? op_sel[63:32] : op_sel[31:0];
    term    = step_q[1] ? {prod_q, 32'd0} : {32'd0, prod_q};
    debit   = (|sum_q[SumW-1:64]) ? '1 : sum_q[63:0];
  end

  // result fields: cleared and filled at lookup, completed after the sum
  always_comb begin
    res_d = res_q;
    if (state_q == ST_LOOK) begin
      res_d = '0;
      unique case (item_q.kind)
        KIND_TRACK: begin
          res_d.status      = !in_table;
          res_d.total_debit = in_table ? ent_new.total : '0;
        end
        KIND_METER: begin
          res_d.status      = !hit;
          res_d.total_debit = hit ? ent.total : '0;
          res_d.delta_sent  = hit ? guarded(item_q.bytes_sent, ent.base_sent) : '0;
          res_d.delta_received =
            hit ? guarded(item_q.bytes_received, ent.base_recv) : '0;
          res_d.delta_mem   = hit ? guarded(item_q.mem_byte_seconds, ent.base_mem) : '0;
        end
        KIND_GONE: res_d.status = !hit;
        KIND_CONFIRM: begin
          res_d.status      = !hit;
          res_d.total_debit = hit ? ent_new.total : '0;
        end
      endcase
    end else if (state_q == ST_FIN) begin
      res_d.age_seconds    = age_q;
      res_d.debit          = debit;
      res_d.charge_request = (debit != '0) && payer_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) fee_q[i] <= '0;
    end else if (cfg_we_i) begin
      fee_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign item_i.ready = (state_q == ST_IDLE);
  assign res_o.valid  = out_valid_q;
  assign res_o.data   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || res_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (item_i.valid) state_q <= ST_LOOK;
        ST_LOOK: begin
          if (item_q.kind == KIND_TRACK && in_table) begin
            valid_q[addr] <= 1'b1;
          end else if (item_q.kind == KIND_GONE && hit) begin
            valid_q[addr] <= 1'b0;
          end
          state_q <= (hit && item_q.kind == KIND_METER) ? ST_AGE : ST_DONE;
        end
        ST_AGE: if (div_done) begin
          step_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd11) begin
            state_q <= ST_MSTART;
          end else if (step_q == 4'd15) begin
            state_q <= ST_FIN;
          end
        end
        ST_MSTART: state_q <= ST_MDIV;
        ST_MDIV: if (div_done) state_q <= ST_MUL;
        ST_FIN: state_q <= ST_DONE;
        ST_DONE: if (!out_valid_q || res_o.ready) state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (item_i.valid) item_q <= item_i.data;
      ST_LOOK: begin
        res_q   <= res_d;
        payer_q <= ent.payer;
        ds_q <= guarded(item_q.bytes_sent, ent.base_sent);
        dr_q <= guarded(item_q.bytes_received, ent.base_recv);
        dm_q <= guarded(item_q.mem_byte_seconds, ent.base_mem);
      end
      ST_AGE: if (div_done) begin
        age_q     <= div_quot[AgeW-1:0];
        sum_q     <= '0;
        memprod_q <= '0;
      end
      ST_MUL: begin
        if (!step_q[0]) begin
          prod_q <= op_half * fee_sel;
        end else if (step_q[3:2] == 2'd2) begin
          memprod_q <= memprod_q + term;
        end else begin
          sum_q <= sum_q + SumW'(term);
        end
      end
      ST_MDIV: if (div_done) sum_q <= sum_q + SumW'(div_quot);
      ST_FIN: res_q <= res_d;
      ST_DONE: if (!out_valid_q || res_o.ready) out_q <= res_q;
      default: ;
    endcase
  end
endmodule

// File: rtl/core/fumd_ram.sv
module fumd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/core/fumd_div.sv
// Divider by one of two fixed divisors. Shift out the power-of-two factor
// first, then take the odd factor one 16-bit digit at a time by reciprocal
// multiplication, a product phase and then a remainder phase per digit.
module fumd_div import fumd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               day_i,
  input  logic [DivBits-1:0] dividend_i,
  output logic               done_o,
  output logic [DivBits-1:0] quotient_o
);
  localparam int Digits = DivBits / 16;

  logic               busy_q;
  logic               done_q;
  logic               phase_q;
  logic               day_q;
  logic [2:0]         cnt_q;
  logic [DivBits-1:0] dvd_q;
  logic [13:0]        rem_q;
  logic [29:0]        cur_q;
  logic [60:0]        prod_q;
  logic [29:0]        cur;
  logic [15:0]        digit;
  logic [29:0]        digit_mul;
  logic [29:0]        rem_full;

  assign cur       = {rem_q, dvd_q[DivBits-1 -: 16]};
  assign digit     = day_q ? prod_q[DayShift+15:DayShift] : prod_q[SecShift+15:SecShift];
  assign digit_mul = digit * (day_q ? DAY_ODD : SEC_ODD);
  assign rem_full  = cur_q - digit_mul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= busy_q && phase_q && (cnt_q == 3'(Digits - 1));
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else if (busy_q) begin
        phase_q <= !phase_q;
        if (phase_q) begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'(Digits - 1)) begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  // quotient digits shift in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      day_q <= day_i;
      rem_q <= '0;
      dvd_q <= day_i ? (dividend_i >> DayPow) : (dividend_i >> SecPow);
    end else if (busy_q) begin
      if (!phase_q) begin
        cur_q  <= cur;
        prod_q <= cur * (day_q ? DAY_RECIP : SEC_RECIP);
      end else begin
        rem_q <= rem_full[13:0];
        dvd_q <= {dvd_q[DivBits-17:0], digit};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule

// File: rtl/core/fumd_checker.sv
module fumd_checker import fumd_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid,
  input logic    out_ready,
  input result_t res
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result changed while stalled");

  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && res.status |-> res.debit == '0 && !res.charge_request &&
      res.total_debit == '0 && res.age_seconds == '0)
    else $error("ignored item carries a payload");

  a_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && res.charge_request |-> res.debit != '0)
    else $error("charge request with zero debit");

  a_deltas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && res.status |-> res.delta_sent == '0 && res.delta_received == '0 &&
      res.delta_mem == '0)
    else $error("ignored item carries deltas");
endmodule

bind flow_usage_metering_debit fumd_checker u_fumd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .res       (res_o.data)
);
